/* design/rdsm_pkg.sv */
package rdsm_pkg;

    localparam int unsigned PATTERN_MAX_DEF = 16;

    localparam logic [7:0] DOT_CODE  = 8'd46;
    localparam logic [7:0] STAR_CODE = 8'd42;

    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_TEXT    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_IDLE    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic       fire;
        cmd_t       cmd;
        logic [7:0] char_code;
    } ctrl_t;

    typedef struct packed {
        logic [7:0] code;
        logic       lead;
        logic       match;
        logic       nxt;
        logic       empty;
        logic       nxt_prev;
        logic       empty_prev;
    } link_t;

endpackage

/* design/rdsm_if.sv */
interface rdsm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] char_code;

    modport source (output valid, output cmd, output char_code, input ready);
    modport sink (input valid, input cmd, input char_code, output ready);
endinterface

interface rdsm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic status;

    modport source (output valid, output matched, output status, input ready);
    modport sink (input valid, input matched, input status, output ready);
endinterface

/* design/rdsm_cell.sv */
module rdsm_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  rdsm_pkg::ctrl_t ctrl,
    input  logic            en,
    input  logic            wr,
    input  rdsm_pkg::link_t link_in,
    output rdsm_pkg::link_t link_out,
    output logic            match_next
);
    import rdsm_pkg::*;

    logic [7:0] code_reg;
    logic       match_reg;
    logic       empty_reg;
    logic       empty_next;
    logic       empty_wr;
    logic       accepts_own;
    logic       accepts_prev;
    logic       is_star;
    logic       nxt;

    assign accepts_own  = (code_reg == DOT_CODE) || (code_reg == ctrl.char_code);
    assign accepts_prev = (link_in.code == DOT_CODE) || (link_in.code == ctrl.char_code);
    assign is_star      = (code_reg == STAR_CODE);

    always_comb
    begin
        if (!en)
        begin
            nxt = 1'b0;
        end
        else if (!is_star)
        begin
            nxt = accepts_own && link_in.match;
        end
        else if (link_in.lead)
        begin
            nxt = 1'b0;
        end
        else
        begin
            nxt = link_in.nxt_prev || (accepts_prev && match_reg);
        end
    end

    assign empty_wr   = (ctrl.char_code == STAR_CODE) && !link_in.lead && link_in.empty_prev;
    assign empty_next = wr ? empty_wr : empty_reg;

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.fire)
        begin
            case (ctrl.cmd)
                CMD_APPEND:  match_next = empty_next;
                CMD_RESTART: match_next = empty_next;
                CMD_TEXT:    match_next = nxt;
                default:     match_next = match_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            empty_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            code_reg <= ctrl.char_code;
        end
    end

    assign link_out.code       = code_reg;
    assign link_out.lead       = 1'b0;
    assign link_out.match      = match_reg;
    assign link_out.nxt        = nxt;
    assign link_out.empty      = empty_reg;
    assign link_out.nxt_prev   = link_in.nxt;
    assign link_out.empty_prev = link_in.empty;

endmodule

/* design/regex_dot_star_matcher_core.sv */
// Whole-pattern matcher for patterns with '.' and '*', built as a row of PATTERN_MAX cells,
// one per pattern byte, each holding its byte and its match bit. Every request (pattern
// append, text byte, restart or no-op) is taken when it is valid and ready, and its result
// is registered and offered on the next cycle. One request per cycle is sustained, as a new
// request is taken while the previous result waits, as long as the result side takes it in
// the same cycle. The cycle time is set by the ripple of star match bits along the cell row.
// Pattern bytes beyond PATTERN_MAX are dropped with status set. There is no clearing pass.
module regex_dot_star_matcher_core #(
    parameter int unsigned PATTERN_MAX = rdsm_pkg::PATTERN_MAX_DEF
) (
    input logic        clk,
    input logic        rst_n,
    rdsm_in_if.sink    item,
    rdsm_out_if.source result
);
    import rdsm_pkg::*;

    localparam int unsigned LW = $clog2(PATTERN_MAX + 1);

    logic [LW-1:0]      length_reg;
    logic [LW-1:0]      length_next;
    logic               match0_reg;
    logic               match0_next;
    logic               out_valid_reg;
    logic               matched_reg;
    logic               status_reg;
    logic               fire;
    logic               full;
    logic               do_append;
    cmd_t               cmd;
    ctrl_t              ctrl;
    link_t              links [PATTERN_MAX+1];
    logic [PATTERN_MAX:0] mvec;

    assign cmd         = cmd_t'(item.cmd);
    assign item.ready  = !out_valid_reg || result.ready;
    assign fire        = item.valid && item.ready;
    assign full        = (length_reg == LW'(PATTERN_MAX));
    assign do_append   = fire && (cmd == CMD_APPEND) && !full;
    assign length_next = do_append ? length_reg + 1'b1 : length_reg;

    assign ctrl.fire      = fire;
    assign ctrl.cmd       = cmd;
    assign ctrl.char_code = item.char_code;

    always_comb
    begin
        match0_next = match0_reg;
        if (fire)
        begin
            case (cmd)
                CMD_APPEND:  match0_next = 1'b1;
                CMD_RESTART: match0_next = 1'b1;
                CMD_TEXT:    match0_next = 1'b0;
                default:     match0_next = match0_reg;
            endcase
        end
    end

    assign links[0].code       = 8'd0;
    assign links[0].lead       = 1'b1;
    assign links[0].match      = match0_reg;
    assign links[0].nxt        = 1'b0;
    assign links[0].empty      = 1'b1;
    assign links[0].nxt_prev   = 1'b0;
    assign links[0].empty_prev = 1'b0;
    assign mvec[0]             = match0_next;

    for (genvar j = 1; j <= PATTERN_MAX; j++)
    begin : g_cell
        rdsm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .en         (LW'(j) <= length_reg),
            .wr         (do_append && (length_reg == LW'(j - 1))),
            .link_in    (links[j-1]),
            .link_out   (links[j]),
            .match_next (mvec[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            match0_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
            matched_reg   <= 1'b0;
            status_reg    <= 1'b0;
        end
        else
        begin
            length_reg <= length_next;
            match0_reg <= match0_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                matched_reg   <= mvec[length_next];
                status_reg    <= (cmd == CMD_APPEND) && full;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.matched = matched_reg;
    assign result.status  = status_reg;

    a_status_only_on_append: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd != CMD_APPEND) |=> !status_reg)
        else $error("status set for a request that is not a pattern append");

    a_dropped_append_keeps_length: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd == CMD_APPEND && full) |=> ($stable(length_reg) && status_reg))
        else $error("dropped pattern byte changed the pattern length");

    a_restart_sets_empty_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (cmd == CMD_RESTART || cmd == CMD_APPEND)) |=> match0_reg)
        else $error("restart did not set the empty-prefix match bit");

    a_text_clears_empty_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd == CMD_TEXT && length_reg == '0) |=> !matched_reg)
        else $error("nonempty text matched an empty pattern");

endmodule
